// File: rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character lookup shared by the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned TOTAL_WIDTH     = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [7:0] CHAR_SPACE  = 8'd32;
  localparam logic [7:0] CHAR_TAB    = 8'd9;
  localparam logic [7:0] CHAR_PLUS   = 8'd43;
  localparam logic [7:0] CHAR_SLASH  = 8'd47;
  localparam logic [5:0] CODE_PLUS   = 6'd62;
  localparam logic [5:0] CODE_SLASH  = 6'd63;
  localparam logic [5:0] CODE_DIGIT0 = 6'd52;
  localparam logic [5:0] CODE_LOWER0 = 6'd26;

  typedef enum logic [1:0] {
    PHASE_FIRST  = 2'd0,
    PHASE_SECOND = 2'd1,
    PHASE_THIRD  = 2'd2,
    PHASE_FOURTH = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0]             data_byte;
    logic                   has_byte;
    logic                   last_result;
    logic [TOTAL_WIDTH-1:0] total_bytes;
  } out_t;

  // Classified character as it waits in the queue.
  typedef struct packed {
    logic [5:0] sextet;
    logic       blank;
    logic       invalid;
    logic       last;
  } cls_t;

  // Returns {invalid, value} for one character of the standard alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = {1'b1, 6'd0};
    if (c >= 8'd65 && c <= 8'd90) begin
      r = {1'b0, 6'(c - 8'd65)};
    end else if (c >= 8'd97 && c <= 8'd122) begin
      r = {1'b0, 6'(c - 8'd97) + CODE_LOWER0};
    end else if (c >= 8'd48 && c <= 8'd57) begin
      r = {1'b0, 6'(c - 8'd48) + CODE_DIGIT0};
    end else if (c == CHAR_PLUS) begin
      r = {1'b0, CODE_PLUS};
    end else if (c == CHAR_SLASH) begin
      r = {1'b0, CODE_SLASH};
    end
    return r;
  endfunction

endpackage

// File: rtl/base64_decoder.sv
// ----------------------------------------------------------------------------
// base64_decoder
// Streaming base64 decoder, standard alphabet, one character per beat.
// ----------------------------------------------------------------------------
// Input beats carry one character and an end_of_message flag. Each valid
// character after the first of a group of four produces one result beat
// with a decoded byte; the flagged final character always produces a result
// beat with last_result set and total_bytes holding the message's byte count.
// Leading blanks are skipped and the first non-alphabet character stops
// decoding until the message ends.
// Throughput is one character per cycle while the receiver keeps taking
// results. An accepted character waits in the queue and is then decoded
// into the result register, from which its result beat is taken.
// When the receiver stalls, the result register holds and the two-entry
// queue absorbs further characters; in_ready falls only once it is full.
// Reset (synchronous) empties the queue and result register and returns the
// decoder to the start of a message; it needs no clearing pass.
// ----------------------------------------------------------------------------
module base64_decoder
  import b64d_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic q_push, q_pop, q_full, q_empty;
  cls_t q_wdata, q_rdata;

  b64d_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  b64d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  b64d_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A result beat mid-message always carries a byte and no count.
  a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_result) |-> (out_data.has_byte && out_data.total_bytes == '0))
    else $error("mid-message result without byte or with count");

  // A result without a byte reads zero.
  a_empty_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_byte) |-> (out_data.data_byte == '0))
    else $error("data_byte nonzero without has_byte");

  // The queue is never popped while empty nor pushed while full.
  a_queue_guard: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty) && !(q_push && q_full))
    else $error("queue overrun or underrun");

  // A stalled result leaves the queue untouched by the back end.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !q_pop)
    else $error("back end advanced while result stalled");

endmodule

// File: rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts input beats and classifies each character for the back end.
// ----------------------------------------------------------------------------
module b64d_front
  import b64d_pkg::*;
(
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  input  logic q_full,
  output logic q_push,
  output cls_t q_wdata
);

  logic [6:0] lut;

  assign lut      = sextet_of(in_data.char_code);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.sextet  = lut[5:0];
    q_wdata.invalid = lut[6];
    q_wdata.blank   = (in_data.char_code == CHAR_SPACE) || (in_data.char_code == CHAR_TAB);
    q_wdata.last    = in_data.end_of_message;
  end

endmodule

// File: rtl/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo
// Short queue of classified characters between the front and back ends.
// ----------------------------------------------------------------------------
module b64d_fifo
  import b64d_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cls_t wdata,
  input  logic pop,
  output cls_t rdata,
  output logic full,
  output logic empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cls_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Runs the decode state per character and holds the result register.
// ----------------------------------------------------------------------------
module b64d_back
  import b64d_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  cls_t q_rdata,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned EXT_W = (COUNT_WIDTH > TOTAL_WIDTH) ? COUNT_WIDTH : TOTAL_WIDTH;

  phase_t                 phase_r, phase_nxt;
  logic [5:0]             held_r, held_nxt;
  logic                   skip_r, skip_nxt;
  logic                   halted_r, halted_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_r, out_nxt;

  logic                   got;
  logic [7:0]             byte_val;
  logic [COUNT_WIDTH-1:0] count_upd;
  logic [EXT_W-1:0]       count_ext;

  assign q_pop     = !q_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    skip_nxt      = skip_r;
    halted_nxt    = halted_r;
    count_nxt     = count_r;
    count_upd     = count_r;
    count_ext     = '0;
    got           = 1'b0;
    byte_val      = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    if (q_pop) begin
      if (!halted_r && !(skip_r && q_rdata.blank)) begin
        skip_nxt = 1'b0;
        if (q_rdata.invalid) begin
          halted_nxt = 1'b1;
        end else begin
          case (phase_r)
            PHASE_SECOND: begin
              byte_val = {held_r, q_rdata.sextet[5:4]};
              got      = 1'b1;
            end
            PHASE_THIRD: begin
              byte_val = {held_r[3:0], q_rdata.sextet[5:2]};
              got      = 1'b1;
            end
            PHASE_FOURTH: begin
              byte_val = {held_r[1:0], q_rdata.sextet};
              got      = 1'b1;
            end
            default: begin
              got = 1'b0;
            end
          endcase
          held_nxt  = q_rdata.sextet;
          phase_nxt = phase_t'(phase_r + 2'd1);
          if (got && (count_r != '1)) begin
            count_upd = count_r + 1'b1;
          end
        end
      end
      count_nxt = count_upd;

      if (got || q_rdata.last) begin
        out_valid_nxt       = 1'b1;
        out_nxt.data_byte   = byte_val;
        out_nxt.has_byte    = got;
        out_nxt.last_result = q_rdata.last;
        out_nxt.total_bytes = '0;
        if (q_rdata.last) begin
          count_ext           = EXT_W'(count_upd);
          out_nxt.total_bytes = (count_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF
                                                               : count_ext[TOTAL_WIDTH-1:0];
        end
      end

      // The final character of a message returns the decoder to its start state.
      if (q_rdata.last) begin
        phase_nxt  = PHASE_FIRST;
        held_nxt   = '0;
        skip_nxt   = 1'b1;
        halted_nxt = 1'b0;
        count_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PHASE_FIRST;
      held_r      <= '0;
      skip_r      <= 1'b1;
      halted_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      skip_r      <= skip_nxt;
      halted_r    <= halted_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for the streaming base64 decoder.
// ----------------------------------------------------------------------------
// A local decoder model predicts the result beat, if any, of each accepted character.
// A monitor compares each accepted result beat, field by field, against the
// oldest prediction. The sequence covers a directed set of corner cases, a
// long receiver hold-off, randomized messages (clean groups, padding, noise,
// embedded blanks), and one long message taken by a fast receiver.
// The sender idles in random bursts and the receiver stalls in random modes.
// ----------------------------------------------------------------------------
module testbench;
  import b64d_pkg::*;

  localparam int          CW            = COUNT_WIDTH_DEF;
  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          RANDOM_CHARS  = 700;
  localparam int          LONG_CHARS    = 200;
  localparam int          HOLD_CYCLES   = 80;
  localparam logic [7:0]  CHAR_PAD      = 8'd61;
  localparam logic [7:0]  CHAR_NUL      = 8'd0;
  localparam logic [7:0]  CHAR_UPPER_A  = 8'd65;
  localparam logic [7:0]  CHAR_LOWER_A  = 8'd97;
  localparam logic [7:0]  CHAR_DIGIT_0  = 8'd48;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  base64_decoder #(.COUNT_WIDTH(CW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Decoder model state.
  phase_t        model_phase;
  logic [5:0]    model_held;
  bit            model_skipping;
  bit            model_halted;
  logic [CW-1:0] model_count;

  out_t expected_beats[$];
  in_t  message_chars[$];
  int   error_count  = 0;
  int   cycle_count  = 0;
  int   burst_left   = 0;
  int   random_chars = 0;

  // Receiver control.
  logic hold_req   = 1'b0;
  logic fast_sink  = 1'b0;
  int   hold_left  = 0;
  int   sink_mode  = 0;
  int   mode_left  = 0;

  function automatic bit char_to_sextet(input logic [7:0] c, output logic [5:0] v);
    v = '0;
    if (c inside {[8'd65:8'd90]}) begin
      v = 6'(c - CHAR_UPPER_A);
      return 1'b1;
    end
    if (c inside {[8'd97:8'd122]}) begin
      v = 6'(c - CHAR_LOWER_A) + CODE_LOWER0;
      return 1'b1;
    end
    if (c inside {[8'd48:8'd57]}) begin
      v = 6'(c - CHAR_DIGIT_0) + CODE_DIGIT0;
      return 1'b1;
    end
    if (c == CHAR_PLUS) begin
      v = CODE_PLUS;
      return 1'b1;
    end
    if (c == CHAR_SLASH) begin
      v = CODE_SLASH;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    if (v < CODE_LOWER0) return CHAR_UPPER_A + 8'(v);
    if (v < CODE_DIGIT0) return CHAR_LOWER_A + 8'(v - CODE_LOWER0);
    if (v < CODE_PLUS)   return CHAR_DIGIT_0 + 8'(v - CODE_DIGIT0);
    if (v == CODE_PLUS)  return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  task automatic clear_decode_state();
    model_phase    = PHASE_FIRST;
    model_held     = '0;
    model_skipping = 1'b1;
    model_halted   = 1'b0;
    model_count    = '0;
  endtask

  task automatic predict_char(input in_t item);
    logic [5:0] v;
    logic [7:0] b;
    bit         got;
    bit         is_blank;
    out_t       res;
    got      = 1'b0;
    b        = '0;
    is_blank = (item.char_code == CHAR_SPACE) || (item.char_code == CHAR_TAB);
    if (!model_halted && !(model_skipping && is_blank)) begin
      model_skipping = 1'b0;
      if (!char_to_sextet(item.char_code, v)) begin
        model_halted = 1'b1;
      end else begin
        case (model_phase)
          PHASE_SECOND: begin
            b   = {model_held, v[5:4]};
            got = 1'b1;
          end
          PHASE_THIRD: begin
            b   = {model_held[3:0], v[5:2]};
            got = 1'b1;
          end
          PHASE_FOURTH: begin
            b   = {model_held[1:0], v};
            got = 1'b1;
          end
          default: ;
        endcase
        model_held  = v;
        model_phase = phase_t'(model_phase + 2'd1);
        if (got && model_count != '1) model_count = model_count + 1'b1;
      end
    end
    if (got || item.end_of_message) begin
      res.data_byte   = b;
      res.has_byte    = got;
      res.last_result = item.end_of_message;
      res.total_bytes = '0;
      if (item.end_of_message) begin
        // A counter wider than the result field reports all ones once it overflows it.
        if (CW > TOTAL_WIDTH && model_count > CW'({TOTAL_WIDTH{1'b1}}))
          res.total_bytes = '1;
        else
          res.total_bytes = TOTAL_WIDTH'(model_count);
      end
      expected_beats.push_back(res);
    end
    if (item.end_of_message) clear_decode_state();
  endtask

  // Offers one character and returns at the edge where it is accepted.
  task automatic send_char(input in_t item, input bit paced);
    int gap;
    if (paced) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) begin
          burst_left = 48;
          gap        = 0;
        end
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predict_char(item);
  endtask

  task automatic push_char(input logic [7:0] c, input bit last);
    in_t item;
    item.char_code      = c;
    item.end_of_message = last;
    message_chars.push_back(item);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_message(input bit paced);
    foreach (message_chars[i]) send_char(message_chars[i], paced);
    message_chars.delete();
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic build_random_message();
    int kind;
    int body;
    kind = $urandom_range(0, 9);
    body = $urandom_range(0, 15);
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) push_char($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB, 0);
    for (int i = 0; i < body; i++) begin
      if (kind == 8 && i == body / 2)
        push_char(CHAR_SPACE, 0);
      else if (kind == 7 && i == body / 2)
        push_char(8'($urandom_range(0, 255)), 0);
      else
        push_char(sextet_to_char(6'($urandom_range(0, 63))), 0);
    end
    if (kind == 6) repeat ($urandom_range(1, 2)) push_char(CHAR_PAD, 0);
    if (kind == 9) repeat ($urandom_range(1, 8)) push_char(8'($urandom_range(0, 255)), 0);
    if (message_chars.size() == 0) push_char(sextet_to_char(6'($urandom_range(0, 63))), 0);
    message_chars[message_chars.size() - 1].end_of_message = 1'b1;
  endtask

  task automatic test_directed();
    push_text("TWFu");
    push_char(CHAR_SPACE, 0);
    push_char(CHAR_TAB, 0);
    push_text("QQ");
    push_text("/+z9");
    push_text("QQ==");
    push_text("Q");
    push_char(CHAR_SPACE, 1);
    push_text("QU JD");
    push_char(CHAR_NUL, 1);
    push_char(8'hFF, 1);
    send_message(1'b1);
    wait_until_drained();
  endtask

  // The receiver holds off while characters keep coming, so the decoder fills.
  task automatic test_output_hold();
    repeat (20) push_char(sextet_to_char(6'($urandom_range(0, 63))), 0);
    message_chars[message_chars.size() - 1].end_of_message = 1'b1;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_message(1'b0);
    wait_until_drained();
  endtask

  task automatic test_random_messages();
    int msgs;
    msgs = 0;
    while (random_chars < RANDOM_CHARS) begin
      build_random_message();
      random_chars += message_chars.size();
      send_message(1'b1);
      msgs++;
      if (msgs % 16 == 0) wait_until_drained();
    end
    wait_until_drained();
  endtask

  // One long message sent back to back into a receiver that never stalls.
  task automatic test_long_message();
    in_t item;
    fast_sink <= 1'b1;
    for (int i = 0; i < LONG_CHARS; i++) begin
      item.char_code      = sextet_to_char(6'($urandom_range(0, 63)));
      item.end_of_message = (i == LONG_CHARS - 1);
      send_char(item, 1'b0);
    end
    wait_until_drained();
    fast_sink <= 1'b0;
  endtask

  initial begin
    clear_decode_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_output_hold();
    test_random_messages();
    test_long_message();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // Receiver: random stall modes, a counted hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      if (mode_left == 0) begin
        sink_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(8, 64);
      end else begin
        mode_left <= mode_left - 1;
      end
      out_ready <= fast_sink || sink_mode == 0 ||
                   (sink_mode == 1 && $urandom_range(0, 1) == 1) ||
                   (sink_mode == 2 && $urandom_range(0, 3) == 0);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Each accepted result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("data_byte", int'(want.data_byte), int'(out_data.data_byte));
        check_field("has_byte", int'(want.has_byte), int'(out_data.has_byte));
        check_field("last_result", int'(want.last_result), int'(out_data.last_result));
        check_field("total_bytes", int'(want.total_bytes), int'(out_data.total_bytes));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

endmodule

// File: base64_decoder.f
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_fifo.sv
rtl/b64d_back.sv
rtl/base64_decoder.sv
test/testbench.sv
